// File: hdl/cle_pkg.sv
// Shared constants for the canonical line editor: status codes, register indexes, characters.
package cle_pkg;

	// Result status codes
	localparam logic [2:0] ST_APPENDED = 3'd0;
	localparam logic [2:0] ST_DROPPED  = 3'd1;
	localparam logic [2:0] ST_ERASED   = 3'd2;
	localparam logic [2:0] ST_NOTHING  = 3'd3;
	localparam logic [2:0] ST_CLEARED  = 3'd4;

	// Input operation codes
	localparam logic OP_KEY   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Configuration register indexes
	localparam logic [2:0] REG_CANON     = 3'd0;
	localparam logic [2:0] REG_ECHO      = 3'd1;
	localparam logic [2:0] REG_ERASE     = 3'd2;
	localparam logic [2:0] REG_WERASE    = 3'd3;
	localparam logic [2:0] REG_KILL      = 3'd4;
	localparam logic [2:0] REG_LINE_END  = 3'd5;
	localparam logic [2:0] REG_FILE_END  = 3'd6;

	// Fixed characters
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_DEL     = 8'h7F;
	localparam logic [7:0] CH_CTRL_HI = 8'h1F;

	// Edit kinds held while popping
	localparam logic [1:0] MODE_ERASE = 2'd0;
	localparam logic [1:0] MODE_WORD  = 2'd1;
	localparam logic [1:0] MODE_KILL  = 2'd2;

endpackage

// File: hdl/cle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/canonical_line_editor.sv
// Canonical line editor: line stack in RAM, popped one byte per step by a small sequencer.
// Append, drop, clear and an edit that removes nothing: one result beat; the next input beat
// is taken only after that result beat has gone out, so an output stall holds it off.
// Each erased byte passes through a RAM read, an evaluate step and an output beat; a kill that
// empties a full line keeps the block busy until its last beat is out. Not ready meanwhile.
// Reset (arst_n low) empties the line and loads the default control characters.
module canonical_line_editor #(
	parameter int LINE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] key_byte
	input  logic        s_tuser,   // [0] operation
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] erased_byte, [9:8] backspaces,
	                               // [16:10] line_length, [23:17] zero
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int FW = $clog2(LINE_DEPTH + 1);

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	// Configuration registers
	logic       canon_q, echo_q;
	logic [7:0] erase_q, werase_q, kill_q, line_end_q, file_end_q;

	// Control state
	logic [2:0]    state_q, ret_q;
	logic [FW-1:0] fill_q;
	logic [1:0]    mode_q;
	logic          word_phase_q;  // 0 skipping blanks, 1 removing the word
	logic          have_pend_q;

	// Pending erased byte, held until the following decision sets its last flag
	logic [7:0]    pend_byte_q;
	logic [1:0]    pend_bs_q;
	logic [FW-1:0] pend_len_q;

	// Output register
	logic          ovalid_q;
	logic [2:0]    ostatus_q;
	logic [7:0]    obyte_q;
	logic [1:0]    obs_q;
	logic [FW-1:0] olen_q;
	logic          olast_q;

	// Input unpack
	logic       in_op;
	logic [7:0] in_key;
	assign in_op  = s_tuser;
	assign in_key = s_tdata;

	logic in_beat, out_beat;
	assign s_tready = (state_q == S_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	// Key classification
	logic is_erase, is_werase, is_kill, is_edit, full;
	assign is_erase  = (in_key == erase_q);
	assign is_werase = (in_key == werase_q);
	assign is_kill   = (in_key == kill_q);
	assign is_edit   = canon_q && (is_erase || is_werase || is_kill);
	assign full      = (fill_q >= FW'(LINE_DEPTH));

	// Line RAM
	logic          ram_we, ram_re;
	logic [FW-1:0] fill_dec;
	logic [7:0]    top_byte;
	assign fill_dec = fill_q - 1'b1;
	assign ram_we   = in_beat && (in_op == cle_pkg::OP_KEY) && !is_edit && !full;
	assign ram_re   = (state_q == S_READ);

	cle_ram #(
		.WIDTH (8),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[AW-1:0]),
		.wdata (in_key),
		.re    (ram_re),
		.raddr (fill_dec[AW-1:0]),
		.rdata (top_byte)
	);

	// Evaluate the top byte against the current edit rule
	logic       top_prot, top_blank, top_ctrl, do_pop, next_phase;
	logic [1:0] top_bs;
	always_comb begin
		top_prot  = (top_byte == cle_pkg::CH_NEWLINE) || (top_byte == line_end_q)
		            || (top_byte == file_end_q);
		top_blank = (top_byte == cle_pkg::CH_SPACE) || (top_byte == cle_pkg::CH_TAB);
		top_ctrl  = (top_byte <= cle_pkg::CH_CTRL_HI) || (top_byte == cle_pkg::CH_DEL);
		top_bs    = echo_q ? (top_ctrl ? 2'd2 : 2'd1) : 2'd0;
		next_phase = word_phase_q;
		case (mode_q)
			cle_pkg::MODE_ERASE: do_pop = !top_prot;
			cle_pkg::MODE_WORD: begin
				do_pop     = !top_prot && (top_blank ? !word_phase_q : 1'b1);
				next_phase = !(!word_phase_q && top_blank);
			end
			cle_pkg::MODE_KILL: do_pop = !top_prot;
			default: do_pop = 1'b0;
		endcase
	end

	// Where to go after a pop
	logic [2:0] after_pop;
	assign after_pop = ((mode_q == cle_pkg::MODE_ERASE) || (fill_dec == '0)) ? S_FIN : S_READ;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canon_q    <= 1'b1;
			echo_q     <= 1'b1;
			erase_q    <= 8'd127;
			werase_q   <= 8'd23;
			kill_q     <= 8'd21;
			line_end_q <= 8'd0;
			file_end_q <= 8'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				cle_pkg::REG_CANON:    canon_q    <= cfg_data[0];
				cle_pkg::REG_ECHO:     echo_q     <= cfg_data[0];
				cle_pkg::REG_ERASE:    erase_q    <= cfg_data;
				cle_pkg::REG_WERASE:   werase_q   <= cfg_data;
				cle_pkg::REG_KILL:     kill_q     <= cfg_data;
				cle_pkg::REG_LINE_END: line_end_q <= cfg_data;
				cle_pkg::REG_FILE_END: file_end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			fill_q       <= '0;
			mode_q       <= cle_pkg::MODE_ERASE;
			word_phase_q <= 1'b0;
			have_pend_q  <= 1'b0;
			ovalid_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						if (in_op == cle_pkg::OP_CLEAR) begin
							fill_q   <= '0;
							ovalid_q <= 1'b1;
							state_q  <= S_OUT;
							ret_q    <= S_IDLE;
						end else if (is_edit) begin
							mode_q       <= is_erase ? cle_pkg::MODE_ERASE :
							                is_werase ? cle_pkg::MODE_WORD : cle_pkg::MODE_KILL;
							word_phase_q <= 1'b0;
							have_pend_q  <= 1'b0;
							state_q      <= (fill_q == '0) ? S_FIN : S_READ;
						end else begin
							if (!full) begin
								fill_q <= fill_q + 1'b1;
							end
							ovalid_q <= 1'b1;
							state_q  <= S_OUT;
							ret_q    <= S_IDLE;
						end
					end
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					word_phase_q <= next_phase;
					if (do_pop) begin
						fill_q      <= fill_dec;
						have_pend_q <= 1'b1;
						if (have_pend_q) begin
							ovalid_q <= 1'b1;
							state_q  <= S_OUT;
							ret_q    <= after_pop;
						end else begin
							state_q <= after_pop;
						end
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					ovalid_q <= 1'b1;
					state_q  <= S_OUT;
					ret_q    <= S_IDLE;
				end
				S_OUT: begin
					if (out_beat) begin
						ovalid_q <= 1'b0;
						state_q  <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload and pending byte
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_beat) begin
					obyte_q <= '0;
					obs_q   <= '0;
					olast_q <= 1'b1;
					if (in_op == cle_pkg::OP_CLEAR) begin
						ostatus_q <= cle_pkg::ST_CLEARED;
						olen_q    <= '0;
					end else if (full) begin
						ostatus_q <= cle_pkg::ST_DROPPED;
						olen_q    <= fill_q;
					end else begin
						ostatus_q <= cle_pkg::ST_APPENDED;
						olen_q    <= fill_q + 1'b1;
					end
				end
			end
			S_EVAL: begin
				if (do_pop) begin
					ostatus_q   <= cle_pkg::ST_ERASED;
					obyte_q     <= pend_byte_q;
					obs_q       <= pend_bs_q;
					olen_q      <= pend_len_q;
					olast_q     <= 1'b0;
					pend_byte_q <= top_byte;
					pend_bs_q   <= top_bs;
					pend_len_q  <= fill_dec;
				end
			end
			S_FIN: begin
				olast_q <= 1'b1;
				if (have_pend_q) begin
					ostatus_q <= cle_pkg::ST_ERASED;
					obyte_q   <= pend_byte_q;
					obs_q     <= pend_bs_q;
					olen_q    <= pend_len_q;
				end else begin
					ostatus_q <= cle_pkg::ST_NOTHING;
					obyte_q   <= '0;
					obs_q     <= '0;
					olen_q    <= fill_q;
				end
			end
			default: ;
		endcase
	end

	// Output pack
	assign m_tvalid = ovalid_q;
	assign m_tdata  = {7'd0, 7'(olen_q), obs_q, obyte_q};
	assign m_tuser  = ostatus_q;
	assign m_tlast  = olast_q;

endmodule

// File: dv/canonical_line_editor_tb.sv
// Testbench for the canonical line editor: directed edits, register sweep and random typing.
`timescale 1ns / 1ps

module canonical_line_editor_tb;

	localparam int DEPTH = 64;

	// One result beat as the block reports it
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] erased;
		logic [1:0] backspaces;
		logic [6:0] line_length;
		logic       last;
	} edit_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	canonical_line_editor #(.LINE_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Line model and register copies
	logic [7:0]   line_model [DEPTH];
	int           line_fill;
	logic         canon_on;
	logic         echo_on;
	logic [7:0]   erase_key;
	logic [7:0]   werase_key;
	logic [7:0]   kill_key;
	logic [7:0]   eol_key;
	logic [7:0]   eof_key;

	edit_result_t pending_results [$];
	int           mismatch_count;
	bit           tx_idle_on;
	bit           rx_stall_on;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Gap length: mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic bit guarded(logic [7:0] b);
		return b == cle_pkg::CH_NEWLINE || b == eol_key || b == eof_key;
	endfunction

	function automatic bit blank(logic [7:0] b);
		return b == cle_pkg::CH_SPACE || b == cle_pkg::CH_TAB;
	endfunction

	function automatic logic [7:0] top_of_line();
		return line_model[line_fill - 1];
	endfunction

	function automatic edit_result_t make_result(logic [2:0] st, logic [7:0] b, logic [1:0] bs);
		edit_result_t r;
		r.status      = st;
		r.erased      = b;
		r.backspaces  = bs;
		r.line_length = 7'(line_fill);
		r.last        = 1'b0;
		return r;
	endfunction

	// Remove the top byte and queue its erase beat
	function automatic void pop_top();
		logic [7:0] b;
		logic [1:0] bs;
		line_fill--;
		b  = line_model[line_fill];
		bs = !echo_on ? 2'd0 :
		     (b <= cle_pkg::CH_CTRL_HI || b == cle_pkg::CH_DEL) ? 2'd2 : 2'd1;
		pending_results.push_back(make_result(cle_pkg::ST_ERASED, b, bs));
	endfunction

	// Work out the beats that one accepted input causes
	function automatic void predict_beat(logic op, logic [7:0] key);
		int first;
		first = pending_results.size();
		if (op == cle_pkg::OP_CLEAR) begin
			line_fill = 0;
			pending_results.push_back(make_result(cle_pkg::ST_CLEARED, 8'd0, 2'd0));
		end else if (canon_on && (key == erase_key || key == werase_key || key == kill_key)) begin
			if (key == erase_key) begin
				if (line_fill > 0 && !guarded(top_of_line()))
					pop_top();
			end else if (key == werase_key) begin
				while (line_fill > 0 && blank(top_of_line()) && !guarded(top_of_line()))
					pop_top();
				while (line_fill > 0 && !blank(top_of_line()) && !guarded(top_of_line()))
					pop_top();
			end else begin
				while (line_fill > 0 && !guarded(top_of_line()))
					pop_top();
			end
			if (pending_results.size() == first)
				pending_results.push_back(make_result(cle_pkg::ST_NOTHING, 8'd0, 2'd0));
		end else if (line_fill >= DEPTH) begin
			pending_results.push_back(make_result(cle_pkg::ST_DROPPED, 8'd0, 2'd0));
		end else begin
			line_model[line_fill] = key;
			line_fill++;
			pending_results.push_back(make_result(cle_pkg::ST_APPENDED, 8'd0, 2'd0));
		end
		pending_results[pending_results.size() - 1].last = 1'b1;
	endfunction

	// Result checker: compare every output beat with the oldest expectation
	always @(posedge clk) begin
		edit_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected beat: status %0d erased_byte %0h", m_tuser, m_tdata[7:0]);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					mismatch_count++;
				end
				if (m_tdata[7:0] != want.erased) begin
					$error("erased_byte: expected %0h, got %0h", want.erased, m_tdata[7:0]);
					mismatch_count++;
				end
				if (m_tdata[9:8] != want.backspaces) begin
					$error("backspaces: expected %0d, got %0d", want.backspaces, m_tdata[9:8]);
					mismatch_count++;
				end
				if (m_tdata[16:10] != want.line_length) begin
					$error("line_length: expected %0d, got %0d", want.line_length,
						m_tdata[16:10]);
					mismatch_count++;
				end
				if (m_tlast != want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// Output side back-pressure
	initial begin
		int hold;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_tready = 1'b0;
				hold--;
			end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
				hold = pick_gap();
				m_tready = (hold == 0);
				if (hold > 0)
					hold--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Send one input beat, with an optional idle gap ahead of it
	task automatic send_beat(input logic op, input logic [7:0] key);
		int gap;
		@(negedge clk);
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = key;
		s_tuser  = op;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_beat(op, key);
	endtask

	task automatic send_key(input logic [7:0] key);
		send_beat(cle_pkg::OP_KEY, key);
	endtask

	task automatic send_clear();
		send_beat(cle_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
	endtask

	// Stop sending and wait until every expected beat is out
	task automatic settle_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write; the block must be idle
	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
			cle_pkg::REG_CANON:    canon_on   = val[0];
			cle_pkg::REG_ECHO:     echo_on    = val[0];
			cle_pkg::REG_ERASE:    erase_key  = val;
			cle_pkg::REG_WERASE:   werase_key = val;
			cle_pkg::REG_KILL:     kill_key   = val;
			cle_pkg::REG_LINE_END: eol_key    = val;
			cle_pkg::REG_FILE_END: eof_key    = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_defaults();
		write_reg(cle_pkg::REG_CANON, 8'd1);
		write_reg(cle_pkg::REG_ECHO, 8'd1);
		write_reg(cle_pkg::REG_ERASE, cle_pkg::CH_DEL);
		write_reg(cle_pkg::REG_WERASE, 8'd23);
		write_reg(cle_pkg::REG_KILL, 8'd21);
		write_reg(cle_pkg::REG_LINE_END, 8'd0);
		write_reg(cle_pkg::REG_FILE_END, 8'd4);
	endtask

	// A byte that neither edits nor is protected
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == erase_key || b == werase_key || b == kill_key || guarded(b));
		return b;
	endfunction

	// Typing-like key mix built around the current control characters
	function automatic logic [7:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 8'(8'h61 + $urandom_range(0, 25));
		if (r < 55) return cle_pkg::CH_SPACE;
		if (r < 60) return cle_pkg::CH_TAB;
		if (r < 64) return cle_pkg::CH_NEWLINE;
		if (r < 72) return erase_key;
		if (r < 77) return werase_key;
		if (r < 81) return kill_key;
		if (r < 83) return eol_key;
		if (r < 85) return eof_key;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_ctrl_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return 8'h00;
		if (r < 25) return 8'hFF;
		if (r < 32) return cle_pkg::CH_SPACE;
		if (r < 37) return cle_pkg::CH_TAB;
		if (r < 70) return 8'($urandom_range(0, 31));
		return 8'($urandom_range(0, 255));
	endfunction

	// Edits on an empty line do nothing; clear on an empty line
	task automatic test_empty_line_edits();
		send_key(erase_key);
		send_key(werase_key);
		send_key(kill_key);
		send_clear();
	endtask

	// Word erase over blanks, kill up to a newline, protected bytes, echo widths
	task automatic test_word_and_kill();
		send_key(8'h61);
		send_key(8'h62);
		send_key(cle_pkg::CH_SPACE);
		send_key(cle_pkg::CH_TAB);
		send_key(werase_key);
		send_key(8'h78);
		send_key(cle_pkg::CH_NEWLINE);
		send_key(8'hFF);
		send_key(8'h01);
		send_key(erase_key);
		send_key(kill_key);
		send_key(erase_key);
		send_key(eof_key);
		send_key(8'h00);
		send_key(werase_key);
		send_clear();
	endtask

	// Canon off, echo off, extreme control characters, blank as protected byte
	task automatic test_register_sweep();
		settle_idle();
		write_reg(cle_pkg::REG_CANON, 8'd0);
		send_key(erase_key);
		send_key(kill_key);
		send_clear();
		settle_idle();
		write_reg(cle_pkg::REG_CANON, 8'd1);
		write_reg(cle_pkg::REG_ECHO, 8'd0);
		write_reg(cle_pkg::REG_ERASE, 8'hFF);
		write_reg(cle_pkg::REG_WERASE, 8'h00);
		write_reg(cle_pkg::REG_KILL, 8'h80);
		write_reg(cle_pkg::REG_LINE_END, cle_pkg::CH_SPACE);
		write_reg(cle_pkg::REG_FILE_END, cle_pkg::CH_TAB);
		send_key(8'h61);
		send_key(cle_pkg::CH_SPACE);
		send_key(8'h00);
		send_key(8'h62);
		send_key(8'hFF);
		send_key(8'h80);
		send_clear();
		settle_idle();
		load_defaults();
	endtask

	// Fill the line past its depth, then kill the whole of it
	task automatic test_full_line();
		send_clear();
		repeat (DEPTH + 2) send_key(plain_byte());
		send_key(kill_key);
		send_key(erase_key);
	endtask

	// Random typing over several register settings
	task automatic test_random_phases();
		for (int ph = 0; ph < 8; ph++) begin
			settle_idle();
			tx_idle_on  = (ph % 3) != 1;
			rx_stall_on = (ph % 4) != 2;
			write_reg(cle_pkg::REG_CANON, 8'($urandom_range(0, 4) != 0));
			write_reg(cle_pkg::REG_ECHO, 8'($urandom_range(0, 1)));
			write_reg(cle_pkg::REG_ERASE, pick_ctrl_char());
			write_reg(cle_pkg::REG_WERASE, pick_ctrl_char());
			write_reg(cle_pkg::REG_KILL, pick_ctrl_char());
			write_reg(cle_pkg::REG_LINE_END, pick_ctrl_char());
			write_reg(cle_pkg::REG_FILE_END, pick_ctrl_char());
			for (int i = 0; i < 28; i++) begin
				// hold off until the block has caught up
				if (ph == 3 && i == 14) begin
					@(negedge clk);
					s_tvalid = 1'b0;
					while (pending_results.size() != 0) @(posedge clk);
				end
				if ($urandom_range(0, 99) < 3)
					send_clear();
				else
					send_key(pick_key());
			end
		end
	endtask

	// Run limit
	initial begin
		#20_000_000;
		$display("canonical_line_editor_tb: done, errors");
		$finish;
	end

	// Main sequence
	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = cle_pkg::REG_CANON;
		cfg_data       = 8'd0;
		s_tvalid       = 1'b0;
		s_tdata        = 8'd0;
		s_tuser        = cle_pkg::OP_KEY;
		mismatch_count = 0;
		tx_idle_on     = 1'b1;
		rx_stall_on    = 1'b1;
		line_fill      = 0;
		canon_on       = 1'b1;
		echo_on        = 1'b1;
		erase_key      = cle_pkg::CH_DEL;
		werase_key     = 8'd23;
		kill_key       = 8'd21;
		eol_key        = 8'd0;
		eof_key        = 8'd4;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_line_edits();
		test_word_and_kill();
		test_register_sweep();
		test_full_line();
		test_random_phases();

		settle_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("canonical_line_editor_tb: done, clean");
		else
			$display("canonical_line_editor_tb: done, errors");
		$finish;
	end

endmodule
